>>> design/sorted_list_table_assert.svh
// Assertion macros for the sorted list table.
`ifndef SORTED_LIST_TABLE_ASSERT_SVH
`define SORTED_LIST_TABLE_ASSERT_SVH

// same-cycle implication
`define SLT_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SLT_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> design/slt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package slt_pkg;

	localparam int CAPACITY = 16;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);

	localparam int VAL_W = 32;
	localparam int POS_W = 5;

	typedef enum logic [1:0] {
		OP_INSERT,
		OP_DELETE,
		OP_SEARCH,
		OP_READ
	} op_t;

	typedef enum logic [2:0] {
		ST_OK,
		ST_FULL,
		ST_NOT_FOUND,
		ST_EMPTY,
		ST_BAD_POS
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_WRL,
		S_FIN
	} state_t;

	typedef struct packed {
		op_t               op;
		logic [VAL_W-1:0]  value;
		logic [POS_W-1:0]  position;
	} req_t;

	typedef struct packed {
		status_t           status;
		logic [POS_W-1:0]  found_position;
		logic [VAL_W-1:0]  read_value;
		logic [POS_W-1:0]  entry_count;
	} result_t;

	typedef struct packed {
		logic gt;
		logic eq;
	} cmp_t;

	typedef struct packed {
		logic ready;
		logic done;
	} ctrl_stat_t;

endpackage

`default_nettype wire

>>> design/slt_mem.sv
`timescale 1ns / 1ps
`default_nettype none

module slt_mem import slt_pkg::*; (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [IDX_W-1:0] waddr,
	input  wire logic [VAL_W-1:0] wdata,
	input  wire logic             re,
	input  wire logic [IDX_W-1:0] raddr,
	output logic      [VAL_W-1:0] rdata
);

	logic [VAL_W-1:0] mem_q [CAPACITY];
	logic [VAL_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

>>> design/slt_cmp.sv
`timescale 1ns / 1ps
`default_nettype none

module slt_cmp import slt_pkg::*; (
	input  wire logic signed [VAL_W-1:0] a,
	input  wire logic signed [VAL_W-1:0] b,
	output cmp_t                         res
);

	always_comb begin
		res.gt = (a > b);
		res.eq = (a == b);
	end

endmodule

`default_nettype wire

>>> design/slt_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module slt_ctrl import slt_pkg::*; (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    start,
	input  wire logic                    ack,
	input  wire req_t                    req,
	output ctrl_stat_t                   stat,
	output result_t                      res,
	output logic                         mem_we,
	output logic        [IDX_W-1:0]      mem_waddr,
	output logic        [VAL_W-1:0]      mem_wdata,
	output logic                         mem_re,
	output logic        [IDX_W-1:0]      mem_raddr,
	input  wire logic   [VAL_W-1:0]      mem_rdata,
	output logic signed [VAL_W-1:0]      cmp_a,
	output logic signed [VAL_W-1:0]      cmp_b,
	input  wire cmp_t                    cmp
);

	state_t           state_q, state_d;
	op_t              op_q;
	logic [VAL_W-1:0] val_q;
	logic [POS_W-1:0] pos_q;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic             iss_act_q;
	logic [IDX_W-1:0] iss_idx_q, iss_end_q;
	logic             vld_s1;
	logic [IDX_W-1:0] idx_s1;
	logic             found_q, found_d;
	logic [IDX_W-1:0] k_q, k_d;
	result_t          res_q, res_d;

	logic             rej, to_wrl, go_wrl, go_fin, stop, asc, last_asc, bad_pos;
	status_t          rej_st;
	logic [IDX_W-1:0] first_idx, last_idx;
	logic [CNT_W-1:0] cnt_m1, cnt_p1;

	assign cmp_a = mem_rdata;
	assign cmp_b = val_q;

	assign cnt_m1   = CNT_W'(cnt_q - CNT_W'(1));
	assign cnt_p1   = CNT_W'(cnt_q + CNT_W'(1));
	assign asc      = (op_q != OP_INSERT);
	assign last_asc = (CNT_W'(idx_s1) == cnt_m1);
	assign bad_pos  = (req.position == '0) || (32'(req.position) > 32'(cnt_q));
	assign stop     = go_wrl || go_fin;

	// start decode, scan step decisions, memory writes, result and count updates
	always_comb begin
		rej       = 1'b0;
		rej_st    = ST_OK;
		to_wrl    = 1'b0;
		first_idx = '0;
		last_idx  = '0;
		unique case (req.op)
			OP_INSERT: begin
				if (cnt_q == CNT_W'(CAPACITY)) begin
					rej    = 1'b1;
					rej_st = ST_FULL;
				end else if (cnt_q == '0) begin
					to_wrl = 1'b1;
				end else begin
					first_idx = IDX_W'(cnt_m1);
				end
			end
			OP_DELETE: begin
				rej      = (cnt_q == '0);
				rej_st   = ST_EMPTY;
				last_idx = IDX_W'(cnt_m1);
			end
			OP_SEARCH: begin
				rej      = (cnt_q == '0);
				rej_st   = ST_NOT_FOUND;
				last_idx = IDX_W'(cnt_m1);
			end
			OP_READ: begin
				rej       = bad_pos;
				rej_st    = ST_BAD_POS;
				first_idx = IDX_W'(req.position - POS_W'(1));
				last_idx  = IDX_W'(req.position - POS_W'(1));
			end
		endcase

		go_wrl    = 1'b0;
		go_fin    = 1'b0;
		found_d   = found_q;
		k_d       = k_q;
		cnt_d     = cnt_q;
		res_d     = res_q;
		mem_we    = 1'b0;
		mem_waddr = idx_s1;
		mem_wdata = mem_rdata;

		if (state_q == S_IDLE && start) begin
			found_d = 1'b0;
			k_d     = '0;
			if (rej) begin
				res_d = '{status: rej_st, found_position: '0, read_value: '0,
					entry_count: POS_W'(cnt_q)};
			end
		end else if (state_q == S_SCAN && vld_s1) begin
			case (op_q)
				OP_INSERT: begin
					if (cmp.gt) begin
						mem_we    = 1'b1;
						mem_waddr = IDX_W'(idx_s1 + IDX_W'(1));
						if (idx_s1 == '0) begin
							go_wrl = 1'b1;
							k_d    = '0;
						end
					end else begin
						go_wrl = 1'b1;
						k_d    = IDX_W'(idx_s1 + IDX_W'(1));
					end
				end
				OP_DELETE: begin
					if (found_q) begin
						mem_we    = 1'b1;
						mem_waddr = IDX_W'(idx_s1 - IDX_W'(1));
					end else if (cmp.eq) begin
						found_d = 1'b1;
						k_d     = idx_s1;
					end
					if (last_asc) begin
						go_fin = 1'b1;
						if (found_d) begin
							cnt_d = cnt_m1;
							res_d = '{status: ST_OK,
								found_position: POS_W'(CNT_W'(k_d) + CNT_W'(1)),
								read_value: '0, entry_count: POS_W'(cnt_m1)};
						end else begin
							res_d = '{status: ST_NOT_FOUND, found_position: '0,
								read_value: '0, entry_count: POS_W'(cnt_q)};
						end
					end
				end
				OP_SEARCH: begin
					if (cmp.eq) begin
						go_fin = 1'b1;
						res_d  = '{status: ST_OK,
							found_position: POS_W'(CNT_W'(idx_s1) + CNT_W'(1)),
							read_value: '0, entry_count: POS_W'(cnt_q)};
					end else if (last_asc) begin
						go_fin = 1'b1;
						res_d  = '{status: ST_NOT_FOUND, found_position: '0,
							read_value: '0, entry_count: POS_W'(cnt_q)};
					end
				end
				default: begin
					go_fin = 1'b1;
					res_d  = '{status: ST_OK, found_position: pos_q,
						read_value: mem_rdata, entry_count: POS_W'(cnt_q)};
				end
			endcase
		end else if (state_q == S_WRL) begin
			mem_we    = 1'b1;
			mem_waddr = k_q;
			mem_wdata = val_q;
			cnt_d     = cnt_p1;
			res_d     = '{status: ST_OK, found_position: POS_W'(CNT_W'(k_q) + CNT_W'(1)),
				read_value: '0, entry_count: POS_W'(cnt_p1)};
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					if (rej) begin
						state_d = S_FIN;
					end else if (to_wrl) begin
						state_d = S_WRL;
					end else begin
						state_d = S_SCAN;
					end
				end
			end
			S_SCAN: begin
				if (go_wrl) begin
					state_d = S_WRL;
				end else if (go_fin) begin
					state_d = S_FIN;
				end
			end
			S_WRL: begin
				state_d = S_FIN;
			end
			S_FIN: begin
				if (ack) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_comb begin
		stat.ready = (state_q == S_IDLE);
		stat.done  = (state_q == S_FIN);
		mem_re     = (state_q == S_SCAN) && iss_act_q;
		mem_raddr  = iss_idx_q;
		res        = res_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			cnt_q     <= '0;
			iss_act_q <= 1'b0;
			vld_s1    <= 1'b0;
			found_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			found_q <= found_d;
			vld_s1  <= mem_re && !stop;
			if (state_q == S_IDLE && start) begin
				iss_act_q <= !rej && !to_wrl;
			end else if (mem_re) begin
				iss_act_q <= !stop && (iss_idx_q != iss_end_q);
			end else if (state_q != S_SCAN) begin
				iss_act_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		k_q    <= k_d;
		res_q  <= res_d;
		idx_s1 <= iss_idx_q;
		if (state_q == S_IDLE && start) begin
			op_q      <= req.op;
			val_q     <= req.value;
			pos_q     <= req.position;
			iss_idx_q <= first_idx;
			iss_end_q <= last_idx;
		end else if (mem_re) begin
			iss_idx_q <= asc ? IDX_W'(iss_idx_q + IDX_W'(1)) : IDX_W'(iss_idx_q - IDX_W'(1));
		end
	end

endmodule

`default_nettype wire

>>> design/sorted_list_table.sv
// Sorted list table: up to CAPACITY signed 32-bit values kept in ascending order.
// Input stream s_axis_*: one item is one operation (insert, delete, search, read).
// Output stream m_axis_*: exactly one result item per operation, in order.
// Entries live in a single-port-write, registered-read memory; one compare unit
// walks them one entry per cycle, shifting entries for insert and delete as it goes.
// s_axis_tready is high only while no operation is in progress, so a new item is
// accepted only after the previous operation has handed its result on.
// The result sits in an output register; while the receiver stalls, the finished
// operation waits there and in the sequencer, and no new item is accepted until
// the result has moved to the output register.
// Reset (arst_n low) empties the table (entry count zero) and drops any pending
// result; memory contents are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module sorted_list_table import slt_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [39:0] s_axis_tdata,  // value[31:0], position[36:32], zero pad
	input  wire logic [1:0]  s_axis_tuser,  // op[1:0]
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic      [47:0] m_axis_tdata,  // found_position[4:0], read_value[36:5],
	                                        // entry_count[41:37], zero pad
	output logic      [2:0]  m_axis_tuser   // status[2:0]
);

	`include "sorted_list_table_assert.svh"

	req_t              req;
	ctrl_stat_t        stat;
	result_t           res, out_q;
	logic              start, ack, out_free, m_valid_q;
	logic              mem_we, mem_re;
	logic [IDX_W-1:0]  mem_waddr, mem_raddr;
	logic [VAL_W-1:0]  mem_wdata, mem_rdata;
	logic signed [VAL_W-1:0] cmp_a, cmp_b;
	cmp_t              cmp;

	assign req.op       = op_t'(s_axis_tuser);
	assign req.value    = s_axis_tdata[31:0];
	assign req.position = s_axis_tdata[36:32];

	assign s_axis_tready = stat.ready;
	assign start         = s_axis_tvalid && stat.ready;
	assign out_free      = !m_valid_q || m_axis_tready;
	assign ack           = stat.done && out_free;

	slt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.ack       (ack),
		.req       (req),
		.stat      (stat),
		.res       (res),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata),
		.cmp_a     (cmp_a),
		.cmp_b     (cmp_b),
		.cmp       (cmp)
	);

	slt_mem u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	slt_cmp u_cmp (
		.a   (cmp_a),
		.b   (cmp_b),
		.res (cmp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (ack) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ack) begin
			out_q <= res;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tuser  = out_q.status;
	assign m_axis_tdata  = {6'b0, out_q.entry_count, out_q.read_value, out_q.found_position};

	`SLT_ASSERT_NXT(a_busy_after_accept, start, !s_axis_tready,
		"item accepted but table still ready")
	`SLT_ASSERT_NOW(a_fail_zero_fields, m_valid_q && (out_q.status != ST_OK),
		(out_q.found_position == '0) && (out_q.read_value == '0),
		"failed operation carries nonzero position or value")
	`SLT_ASSERT_NOW(a_ok_has_position, m_valid_q && (out_q.status == ST_OK),
		out_q.found_position != '0, "successful operation without position")
	`SLT_ASSERT_NXT(a_result_held, stat.done && !out_free, stat.done,
		"finished result dropped while output stalled")

endmodule

`default_nettype wire

>>> tb/sv/sorted_list_checker.sv
`timescale 1ns / 1ps

module sorted_list_checker import slt_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [39:0] s_tdata,  // value[31:0], position[36:32], zero pad
	input  logic [1:0]  s_tuser,  // op[1:0]
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [47:0] m_tdata,  // found_position[4:0], read_value[36:5], entry_count[41:37]
	input  logic [2:0]  m_tuser,  // status[2:0]
	output int          errors,
	output int          pending,
	output int          checked
);

	localparam int PRINT_CAP = 40;

	logic signed [VAL_W-1:0] shadow_entries [CAPACITY];
	int shadow_fill;
	result_t predicted_results [$];

	function automatic int first_index_of(logic signed [VAL_W-1:0] v);
		int i;
		for (i = 0; i < shadow_fill; i++)
			if (shadow_entries[i] == v)
				return i;
		return shadow_fill;
	endfunction

	function automatic result_t apply_table_op(op_t op, logic signed [VAL_W-1:0] v,
			logic [POS_W-1:0] pos);
		result_t r;
		int k;
		int i;
		r = '0;
		r.status = ST_OK;
		case (op)
			OP_INSERT: begin
				if (shadow_fill >= CAPACITY) begin
					r.status = ST_FULL;
				end else begin
					k = 0;
					while (k < shadow_fill && shadow_entries[k] <= v)
						k++;
					for (i = shadow_fill; i > k; i--)
						shadow_entries[i] = shadow_entries[i - 1];
					shadow_entries[k] = v;
					shadow_fill++;
					r.found_position = POS_W'(k + 1);
				end
			end
			OP_DELETE: begin
				if (shadow_fill == 0) begin
					r.status = ST_EMPTY;
				end else begin
					k = first_index_of(v);
					if (k >= shadow_fill) begin
						r.status = ST_NOT_FOUND;
					end else begin
						for (i = k; i + 1 < shadow_fill; i++)
							shadow_entries[i] = shadow_entries[i + 1];
						shadow_fill--;
						r.found_position = POS_W'(k + 1);
					end
				end
			end
			OP_SEARCH: begin
				k = first_index_of(v);
				if (k >= shadow_fill)
					r.status = ST_NOT_FOUND;
				else
					r.found_position = POS_W'(k + 1);
			end
			default: begin
				if (pos == 0 || pos > shadow_fill) begin
					r.status = ST_BAD_POS;
				end else begin
					r.found_position = pos;
					r.read_value = shadow_entries[pos - 1];
				end
			end
		endcase
		r.entry_count = POS_W'(shadow_fill);
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		if (errors < PRINT_CAP)
			$display("%0t: %s mismatch, got 0x%0h, expected 0x%0h", $time, what, got, want);
		errors++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			shadow_fill = 0;
			predicted_results.delete();
			pending = 0;
		end else begin
			if (s_tvalid && s_tready)
				predicted_results.push_back(apply_table_op(op_t'(s_tuser), s_tdata[31:0],
					s_tdata[36:32]));
			if (m_tvalid && m_tready) begin
				if (predicted_results.size() == 0) begin
					report_mismatch("unexpected result", m_tdata[31:0], 32'd0);
				end else begin
					want = predicted_results.pop_front();
					checked++;
					if (m_tuser !== want.status)
						report_mismatch("status", 32'(m_tuser), 32'(want.status));
					if (m_tdata[4:0] !== want.found_position)
						report_mismatch("found_position", 32'(m_tdata[4:0]),
							32'(want.found_position));
					if (m_tdata[36:5] !== want.read_value)
						report_mismatch("read_value", m_tdata[36:5], want.read_value);
					if (m_tdata[41:37] !== want.entry_count)
						report_mismatch("entry_count", 32'(m_tdata[41:37]),
							32'(want.entry_count));
				end
			end
			pending = predicted_results.size();
		end
	end

endmodule

>>> tb/sv/tb_sorted_list_table.sv
`timescale 1ns / 1ps

module tb_sorted_list_table;
	import slt_pkg::*;

	localparam int QUIET_LIMIT  = 4000;
	localparam int DRAIN_CYCLES = 40;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [39:0] s_tdata = '0;
	logic [1:0]  s_tuser = OP_INSERT;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [47:0] m_tdata;
	logic [2:0]  m_tuser;

	int errors;
	int pending;
	int checked;

	int sender_idle_pct = 0;
	int stall_pct = 0;
	int quiet_cycles = 0;
	bit timed_out = 1'b0;
	int op_count [4] = '{0, 0, 0, 0};
	logic [31:0] recent_inserts [$];

	sorted_list_table dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_tvalid),
		.s_axis_tready (s_tready),
		.s_axis_tdata  (s_tdata),
		.s_axis_tuser  (s_tuser),
		.m_axis_tvalid (m_tvalid),
		.m_axis_tready (m_tready),
		.m_axis_tdata  (m_tdata),
		.m_axis_tuser  (m_tuser)
	);

	sorted_list_checker u_checker (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.errors   (errors),
		.pending  (pending),
		.checked  (checked)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(negedge clk)
		m_tready = ($urandom_range(99) >= stall_pct);

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles = 0;
		else if (quiet_cycles < QUIET_LIMIT)
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT)
			timed_out = 1'b1;
	end

	// called at a falling edge, returns at the falling edge after acceptance
	task automatic send_item(op_t op, logic [31:0] v, logic [4:0] pos);
		while ($urandom_range(99) < sender_idle_pct) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tuser = op;
		s_tdata = {3'b000, pos, v};
		do @(posedge clk); while (!s_tready);
		op_count[op]++;
		if (op == OP_INSERT) begin
			recent_inserts.push_back(v);
			if (recent_inserts.size() > 16)
				void'(recent_inserts.pop_front());
		end
		@(negedge clk);
	endtask

	// alternates fill-heavy and drain-heavy stretches so the table swings
	// between full and empty
	task automatic run_random(int n, int idle, int stall);
		op_t op;
		logic [31:0] v;
		logic [4:0] pos;
		int roll;
		int k;
		bit filling;
		sender_idle_pct = idle;
		stall_pct = stall;
		filling = 1'b1;
		for (k = 0; k < n; k++) begin
			if (k % 40 == 39)
				filling = !filling;
			roll = $urandom_range(99);
			if (roll < (filling ? 55 : 25))
				op = OP_INSERT;
			else if (roll < (filling ? 75 : 65))
				op = OP_DELETE;
			else if (roll < 85)
				op = OP_SEARCH;
			else
				op = OP_READ;
			case ($urandom_range(9))
				0, 1, 2, 3, 4: v = 32'($urandom_range(16)) - 32'd8;
				5, 6: begin
					if (recent_inserts.size() != 0)
						v = recent_inserts[$urandom_range(recent_inserts.size() - 1)];
					else
						v = $urandom;
				end
				7: begin
					case ($urandom_range(3))
						0: v = 32'h8000_0000;
						1: v = 32'h7fff_ffff;
						2: v = 32'h0000_0000;
						default: v = 32'hffff_ffff;
					endcase
				end
				default: v = $urandom;
			endcase
			pos = ($urandom_range(99) < 85) ? 5'($urandom_range(17)) : 5'($urandom_range(31));
			send_item(op, v, pos);
		end
	endtask

	initial begin
		int i;
		fork
			begin
				repeat (7) @(posedge clk);
				@(negedge clk);
				arst_n = 1'b1;

				send_item(OP_DELETE, 32'd7, 5'd1);
				send_item(OP_SEARCH, 32'd7, 5'd1);
				send_item(OP_READ, 32'd0, 5'd0);
				send_item(OP_INSERT, 32'd0, 5'd0);
				send_item(OP_INSERT, 32'h7fff_ffff, 5'd31);
				send_item(OP_INSERT, 32'h8000_0000, 5'd16);
				send_item(OP_INSERT, 32'd0, 5'd1);
				send_item(OP_SEARCH, 32'd0, 5'd2);
				send_item(OP_READ, 32'd0, 5'd4);
				send_item(OP_DELETE, 32'd5, 5'd3);
				send_item(OP_DELETE, 32'h7fff_ffff, 5'd0);
				for (i = 0; i < 13; i++)
					send_item(OP_INSERT, 32'($urandom_range(40)) - 32'd20,
						5'($urandom_range(31)));
				send_item(OP_INSERT, 32'hffff_ffff, 5'd0);
				send_item(OP_READ, 32'd0, 5'd16);
				send_item(OP_READ, 32'd0, 5'd17);
				send_item(OP_DELETE, 32'h8000_0000, 5'd8);

				run_random(325, 0, 0);
				run_random(325, 70, 0);
				run_random(325, 0, 70);
				run_random(325, 34, 34);

				s_tvalid = 1'b0;
				do @(negedge clk); while (pending != 0);
				repeat (DRAIN_CYCLES) @(negedge clk);
			end
			wait (timed_out);
		join_any
		$display("Ran %0d operations (insert %0d, delete %0d, search %0d, read %0d)",
			op_count[OP_INSERT] + op_count[OP_DELETE] + op_count[OP_SEARCH] + op_count[OP_READ],
			op_count[OP_INSERT], op_count[OP_DELETE], op_count[OP_SEARCH], op_count[OP_READ]);
		$display("under four sender/receiver pressure mixes; %0d results checked, %0d errors",
			checked, errors);
		if (!timed_out && errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
